// ----- hw/rtl/bbr_pkg.sv -----
// bbr_pkg: types, constants and helper functions of the bad block remap unit
// depends on nothing; imported by bad_block_remap_unit and tb
`timescale 1ns / 1ps

package bbr_pkg;

   // disk geometry limits
   localparam int MAX_SECTORS = 4096;
   localparam int SPARE_LIMIT = 64;
   localparam int MIN_SPARE   = 4;

   localparam int SECTOR_W = $clog2(MAX_SECTORS);       // sector index bits
   localparam int NUM_W    = $clog2(MAX_SECTORS + 1);   // sector count bits
   localparam int CNT_W    = $clog2(SPARE_LIMIT + 1);   // spare count bits
   localparam int REMAP_W  = 32;

   // bitmap memory organisation: one row of bits per memory word
   localparam int ROW_BITS = 64;
   localparam int ROW_W    = $clog2(ROW_BITS);
   localparam int ROWS     = MAX_SECTORS / ROW_BITS;
   localparam int ADDR_W   = (ROWS > 1) ? $clog2(ROWS) : 1;

   // remainder unit: DIGIT dividend bits per cycle
   localparam int DIGIT     = 4;
   localparam int DIV_STEPS = (SECTOR_W + DIGIT - 1) / DIGIT;
   localparam int DIV_W     = DIV_STEPS * DIGIT;
   localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // request codes; code 3 behaves as a query
   localparam logic [1:0] REQ_MARK   = 2'd0;
   localparam logic [1:0] REQ_QUERY  = 2'd1;
   localparam logic [1:0] REQ_ACCESS = 2'd2;

   localparam logic [NUM_W-1:0] TOTAL_RESET = NUM_W'(4096);

   typedef struct packed {
      logic [1:0]  req_type;
      logic [31:0] sector;
   } bbr_req_type;

   typedef struct packed {
      logic               status;
      logic [11:0]        phys_sector;
      logic               was_remapped;
      logic               bad_flag;
      logic [12:0]        bad_total;
      logic [REMAP_W-1:0] remap_total;
   } bbr_rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0]    n;       // effective sector count
      logic [CNT_W-1:0]    cnt;     // spare pool size
      logic [SECTOR_W-1:0] first;   // first spare sector
   } bbr_geom_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_UPDATE
   } bbr_state_type;

   function automatic bbr_geom_type spare_geom(input logic [NUM_W-1:0] total);
      bbr_geom_type      g;
      logic [NUM_W-1:0]  quarter;
      if (total < NUM_W'(MIN_SPARE)) begin
         g.n = NUM_W'(MIN_SPARE);
      end else if (total > NUM_W'(MAX_SECTORS)) begin
         g.n = NUM_W'(MAX_SECTORS);
      end else begin
         g.n = total;
      end
      quarter = g.n >> 2;
      if (quarter > NUM_W'(SPARE_LIMIT)) begin
         g.cnt = CNT_W'(SPARE_LIMIT);
      end else if (quarter < NUM_W'(MIN_SPARE)) begin
         g.cnt = CNT_W'(MIN_SPARE);
      end else begin
         g.cnt = quarter[CNT_W-1:0];
      end
      g.first = SECTOR_W'(g.n - NUM_W'(g.cnt));
      return g;
   endfunction

   // restoring remainder over one digit of the dividend, msb first
   function automatic logic [CNT_W-1:0] mod_digit(input logic [CNT_W-1:0] rem,
                                                  input logic [DIGIT-1:0] bits,
                                                  input logic [CNT_W-1:0] cnt);
      logic [CNT_W:0]   r;
      logic [CNT_W-1:0] acc;
      acc = rem;
      for (int i = DIGIT - 1; i >= 0; i--) begin
         r = {acc, bits[i]};
         if (r >= {1'b0, cnt}) begin
            r = r - {1'b0, cnt};
         end
         acc = r[CNT_W-1:0];
      end
      return acc;
   endfunction

endpackage

// ----- hw/rtl/bad_block_remap_unit.sv -----
// bad_block_remap_unit: bad sector bitmap, counters and spare pool translation
// depends on bbr_pkg
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; its result appears on
// rsp_data for exactly one cycle with rsp_strobe and must be taken then, as there is
// no way to hold it off. Mark and query transactions, and any transaction naming an
// out-of-range sector, go from acceptance straight to the update state: the bitmap
// row is read at acceptance and written back in the update cycle. In-range access
// transactions pass through the divide state first, where the spare slot
// remainder is worked out 4 bits a cycle over the 12-bit sector. The bitmap sits in a
// 64 x 64-bit memory; after reset and after every csr write a clearing pass zeroes
// it one row a cycle while busy stays high. A csr write also zeroes both counters.

module bad_block_remap_unit
   import bbr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  bbr_req_type         req_data,
   output logic                rsp_strobe,
   output bbr_rsp_type         rsp_data,
   input  logic                csr_write_en,
   input  logic [NUM_W-1:0]    csr_write_data
);

   bbr_state_type       state_ff, state_in;
   bbr_geom_type        geom_ff;
   logic [ADDR_W-1:0]   clr_row_ff;
   logic [1:0]          type_ff;
   logic [SECTOR_W-1:0] sec_ff;
   logic                oor_ff;
   logic [DIV_W-1:0]    div_sh_ff;
   logic [CNT_W-1:0]    rem_ff;
   logic [STEP_W-1:0]   step_ff;
   logic [12:0]         bad_cnt_ff, bad_cnt_in;
   logic [REMAP_W-1:0]  remap_cnt_ff, remap_cnt_in;
   logic                rsp_strobe_ff;
   bbr_rsp_type         rsp_ff, rsp_in;

   logic [ROW_BITS-1:0] bitmap_mem [ROWS];
   logic [ROW_BITS-1:0] rd_row_ff;
   logic                mem_wr_en;
   logic [ADDR_W-1:0]   mem_wr_addr;
   logic [ROW_BITS-1:0] mem_wr_data;

   logic                accept;
   logic                req_oor;
   logic                cur_bit;
   logic [SECTOR_W-1:0] spare_slot;
   logic                remap_hit;

   assign accept = (state_ff == ST_IDLE) && start;
   assign req_oor = (req_data.sector[31:NUM_W] != '0) ||
                    (req_data.sector[NUM_W-1:0] >= geom_ff.n);

   assign cur_bit    = rd_row_ff[sec_ff[ROW_W-1:0]];
   assign spare_slot = geom_ff.first + SECTOR_W'(rem_ff);
   assign remap_hit  = !oor_ff && (type_ff == REQ_ACCESS) && cur_bit &&
                       (spare_slot != sec_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_row_ff == ADDR_W'(ROWS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) begin
               if (!req_oor && (req_data.req_type == REQ_ACCESS)) state_in = ST_DIV;
               else state_in = ST_UPDATE;
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_W'(DIV_STEPS - 1)) state_in = ST_UPDATE;
         end
         ST_UPDATE: state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
      // a csr write restarts the clearing pass
      if (csr_write_en) state_in = ST_CLEAR;
   end

   // outputs of the sequencer
   always_comb begin
      busy         = 1'b1;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = sec_ff[SECTOR_W-1:ROW_W];
      mem_wr_data  = rd_row_ff;
      bad_cnt_in   = bad_cnt_ff;
      remap_cnt_in = remap_cnt_ff;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_row_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: busy = 1'b0;
         ST_DIV: ;
         ST_UPDATE: begin
            if (!oor_ff && (type_ff == REQ_MARK) && !cur_bit) begin
               mem_wr_en = 1'b1;
               mem_wr_data[sec_ff[ROW_W-1:0]] = 1'b1;
               bad_cnt_in = bad_cnt_ff + 13'd1;
            end
            if (remap_hit) remap_cnt_in = remap_cnt_ff + REMAP_W'(1);
            rsp_in.status       = oor_ff;
            rsp_in.phys_sector  = '0;
            rsp_in.was_remapped = remap_hit;
            rsp_in.bad_flag     = 1'b0;
            rsp_in.bad_total    = bad_cnt_in;
            rsp_in.remap_total  = remap_cnt_in;
            if (!oor_ff) begin
               rsp_in.bad_flag = (type_ff == REQ_MARK) ? 1'b1 : cur_bit;
               if (type_ff == REQ_ACCESS) begin
                  rsp_in.phys_sector = cur_bit ? spare_slot : sec_ff;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         geom_ff       <= spare_geom(TOTAL_RESET);
         clr_row_ff    <= '0;
         bad_cnt_ff    <= '0;
         remap_cnt_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
         step_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_UPDATE);
         if (csr_write_en) begin
            geom_ff      <= spare_geom(csr_write_data);
            clr_row_ff   <= '0;
            bad_cnt_ff   <= '0;
            remap_cnt_ff <= '0;
         end else begin
            if (state_ff == ST_CLEAR) clr_row_ff <= clr_row_ff + ADDR_W'(1);
            bad_cnt_ff   <= bad_cnt_in;
            remap_cnt_ff <= remap_cnt_in;
         end
         if (accept) step_ff <= '0;
         else if (state_ff == ST_DIV) step_ff <= step_ff + STEP_W'(1);
      end
   end

   // transaction payload and remainder unit
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         type_ff   <= req_data.req_type;
         sec_ff    <= req_data.sector[SECTOR_W-1:0];
         oor_ff    <= req_oor;
         div_sh_ff <= DIV_W'(req_data.sector[SECTOR_W-1:0]);
         rem_ff    <= '0;
      end else if (state_ff == ST_DIV) begin
         rem_ff    <= mod_digit(rem_ff, div_sh_ff[DIV_W-1 -: DIGIT], geom_ff.cnt);
         div_sh_ff <= div_sh_ff << DIGIT;
      end
   end

   // bitmap memory; the row is read at acceptance and written back in the update
   // cycle, and the next read comes no earlier than the edge after that write
   always_ff @(posedge clock) begin
      if (mem_wr_en) bitmap_mem[mem_wr_addr] <= mem_wr_data;
      if (accept) rd_row_ff <= bitmap_mem[req_data.sector[SECTOR_W-1:ROW_W]];
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_wr_en)
      else $error("bitmap written while idle");

   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(state_ff) == ST_UPDATE))
      else $error("result strobe without an update cycle");

   a_bad_cnt_stable: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && !$past(csr_write_en) && ($past(state_ff) != ST_UPDATE))
      |-> $stable(bad_cnt_ff))
      else $error("bad counter moved outside an update");

   a_remap_in_pool: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.was_remapped) |-> (rsp_data.phys_sector >= geom_ff.first))
      else $error("remapped sector outside the spare pool");

endmodule

// ----- sim/tb.sv -----
// tb: self-checking testbench for bad_block_remap_unit, with its own shadow of
// the bad sector map, the counters and the spare pool translation
// depends on bbr_pkg and bad_block_remap_unit
`timescale 1ns / 1ps

module tb;
   import bbr_pkg::*;

   // unused request code, behaves as a query
   localparam logic [1:0] REQ_SPARE_CODE = 2'd3;
   localparam int         DRAIN_LIMIT    = 2000;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                start          = 1'b0;
   logic                busy;
   bbr_req_type         req_data       = '0;
   logic                rsp_strobe;
   bbr_rsp_type         rsp_data;
   logic                csr_write_en   = 1'b0;
   logic [NUM_W-1:0]    csr_write_data = '0;

   // shadow of the disk state
   logic                shadow_bad [MAX_SECTORS];
   logic [12:0]         shadow_bad_count;
   logic [31:0]         shadow_remap_count;
   logic [NUM_W-1:0]    shadow_total;

   bbr_rsp_type         translations_due [$];
   int                  err_count = 0;

   bad_block_remap_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_data       (req_data),
      .rsp_strobe     (rsp_strobe),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int disk_size();
      int n;
      n = int'(shadow_total);
      if (n < MIN_SPARE) n = MIN_SPARE;
      if (n > MAX_SECTORS) n = MAX_SECTORS;
      return n;
   endfunction

   function automatic int spare_size(input int n);
      int c;
      c = SPARE_LIMIT;
      if (c > n / 4) c = n / 4;
      if (c < MIN_SPARE) c = MIN_SPARE;
      return c;
   endfunction

   // a csr write behaves like formatting a fresh disk
   function automatic void format_disk(input logic [NUM_W-1:0] total);
      shadow_total = total;
      foreach (shadow_bad[i]) shadow_bad[i] = 1'b0;
      shadow_bad_count   = '0;
      shadow_remap_count = '0;
   endfunction

   function automatic bbr_rsp_type predict_translation(input bbr_req_type r);
      bbr_rsp_type o;
      int          n;
      int          cnt;
      int          sec;
      int          phys;
      o = '0;
      n = disk_size();
      if (r.sector >= 32'(n)) begin
         o.status = 1'b1;
      end else begin
         sec = int'(r.sector);
         case (r.req_type)
            REQ_MARK: begin
               if (!shadow_bad[sec]) begin
                  shadow_bad[sec]  = 1'b1;
                  shadow_bad_count = shadow_bad_count + 13'd1;
               end
               o.bad_flag = 1'b1;
            end
            REQ_ACCESS: begin
               o.bad_flag = shadow_bad[sec];
               phys = sec;
               if (shadow_bad[sec]) begin
                  cnt  = spare_size(n);
                  phys = (n - cnt) + (sec % cnt);
               end
               o.phys_sector = 12'(phys);
               // a spare slot that lands on the sector itself is no remap
               if (phys != sec) begin
                  o.was_remapped     = 1'b1;
                  shadow_remap_count = shadow_remap_count + 32'd1;
               end
            end
            default: begin
               o.bad_flag = shadow_bad[sec];
            end
         endcase
      end
      o.bad_total   = shadow_bad_count;
      o.remap_total = shadow_remap_count;
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         err_count++;
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      bbr_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (translations_due.size() == 0) begin
            $error("result with no transaction outstanding");
            err_count++;
         end else begin
            want = translations_due.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_data.status));
            check_field("phys_sector", 32'(want.phys_sector), 32'(rsp_data.phys_sector));
            check_field("was_remapped", 32'(want.was_remapped), 32'(rsp_data.was_remapped));
            check_field("bad_flag", 32'(want.bad_flag), 32'(rsp_data.bad_flag));
            check_field("bad_total", 32'(want.bad_total), 32'(rsp_data.bad_total));
            check_field("remap_total", want.remap_total, rsp_data.remap_total);
         end
      end
   end

   // every task below starts and ends just after a rising edge
   task automatic send_request(input logic [1:0] kind, input logic [31:0] sec);
      bbr_req_type item;
      item.req_type = kind;
      item.sector   = sec;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      translations_due.push_back(predict_translation(item));
   endtask

   task automatic idle_cycles(input int k);
      repeat (k) begin
         @(negedge clock);
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_results_drained();
      @(negedge clock);
      start <= 1'b0;
      do @(posedge clock); while (translations_due.size() != 0);
   endtask

   task automatic write_total(input logic [NUM_W-1:0] value);
      wait_results_drained();
      repeat (8) @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      format_disk(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_full_disk();
      send_request(REQ_MARK, 32'd0);
      send_request(REQ_MARK, 32'd0);          // already bad, no count
      send_request(REQ_QUERY, 32'd0);
      send_request(REQ_ACCESS, 32'd0);        // into the spare pool
      send_request(REQ_ACCESS, 32'd1);
      send_request(REQ_SPARE_CODE, 32'd0);
      wait_results_drained();
      send_request(REQ_MARK, 32'd4095);
      send_request(REQ_ACCESS, 32'd4095);     // spare slot is the sector itself
      send_request(REQ_MARK, 32'd100);
      send_request(REQ_ACCESS, 32'd100);
      send_request(REQ_ACCESS, 32'd4096);     // first out of range
      send_request(REQ_MARK, 32'd4096);
      send_request(REQ_QUERY, 32'hFFFF_FFFF);
      send_request(REQ_ACCESS, 32'h8000_0000);
      send_request(REQ_QUERY, 32'd1);
   endtask

   task automatic test_small_disks();
      write_total(NUM_W'(4));                 // pool covers the whole disk
      send_request(REQ_MARK, 32'd3);
      send_request(REQ_ACCESS, 32'd3);
      send_request(REQ_ACCESS, 32'd4);
      write_total(NUM_W'(5));
      send_request(REQ_MARK, 32'd0);
      send_request(REQ_ACCESS, 32'd0);
      send_request(REQ_MARK, 32'd4);
      send_request(REQ_ACCESS, 32'd4);
   endtask

   task automatic test_clamped_sizes();
      write_total(NUM_W'(0));                 // clamps up to 4 sectors
      send_request(REQ_ACCESS, 32'd3);
      send_request(REQ_QUERY, 32'd4);
      write_total({NUM_W{1'b1}});             // clamps down to the full disk
      send_request(REQ_MARK, 32'd4095);
      send_request(REQ_ACCESS, 32'd4095);
      send_request(REQ_ACCESS, 32'd4096);
   endtask

   task automatic test_random_traffic(input logic [NUM_W-1:0] total, input int idle_pct,
                                      input int count);
      int          n;
      int          cnt;
      int          sel;
      logic [1:0]  kind;
      logic [31:0] sec;
      write_total(total);
      n   = disk_size();
      cnt = spare_size(n);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < idle_pct) idle_cycles($urandom_range(1, 5));
         if ($urandom_range(0, 99) == 0) wait_results_drained();
         sel = $urandom_range(0, 99);
         if (sel < 30) kind = REQ_MARK;
         else if (sel < 42) kind = REQ_QUERY;
         else if (sel < 90) kind = REQ_ACCESS;
         else kind = REQ_SPARE_CODE;
         // mostly the low sectors and the spare pool, so marks and accesses meet
         sel = $urandom_range(0, 99);
         if (sel < 35) sec = $urandom_range(0, (n < 32) ? n - 1 : 31);
         else if (sel < 55) sec = $urandom_range(n - cnt, n - 1);
         else if (sel < 80) sec = $urandom_range(0, n - 1);
         else if (sel < 90) sec = 32'(n) + $urandom_range(0, 3);
         else sec = $urandom;
         send_request(kind, sec);
      end
   endtask

   initial begin : run
      logic [NUM_W-1:0] totals [10];
      int               idle_pcts [3];
      int               waited;
      totals    = '{NUM_W'(4096), {NUM_W{1'b1}}, NUM_W'(4), NUM_W'(0), NUM_W'(5),
                    NUM_W'(17), NUM_W'(255), NUM_W'(256), NUM_W'(1000), '0};
      idle_pcts = '{0, 47, 20};
      totals[9] = NUM_W'($urandom_range(0, 8191));
      format_disk(TOTAL_RESET);
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_full_disk();
      test_small_disks();
      test_clamped_sizes();
      for (int p = 0; p < 10; p++) begin
         test_random_traffic(totals[p], idle_pcts[p % 3], 60);
      end

      @(negedge clock);
      start  <= 1'b0;
      waited = 0;
      while (translations_due.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (translations_due.size() != 0) begin
         $error("%0d transactions never answered", translations_due.size());
         err_count++;
      end
      if (err_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
